>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dmrk_pkg.sv
// ---------------------------------------------------------------------------
// dmrk_pkg
// Types, constants and drive encoding for the dual motor ramp/kickstart core.
// ---------------------------------------------------------------------------
package dmrk_pkg;

  localparam int PWM_WIDTH        = 8;
  localparam int KICK_TIMER_WIDTH = 16;

  localparam int PWM_MAX = (1 << PWM_WIDTH) - 1;
  localparam logic [KICK_TIMER_WIDTH-1:0] KICK_AGE_MAX = '1;

  // magnitude must hold 256 (negated -256) and PWM_MAX
  localparam int MAG_W = (PWM_WIDTH >= 10) ? PWM_WIDTH + 1 : 10;

  localparam int SPEED_W = 9;
  localparam int TGT_W   = 9;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_DURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_PWM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_PWM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RIGHT   = 3'd6;

  localparam logic [7:0]  RST_RAMP_PERIOD    = 8'd5;
  localparam logic [7:0]  RST_SLEW_STEP      = 8'd2;
  localparam logic [15:0] RST_KICK_DURATION  = 16'd50;
  localparam logic [7:0]  RST_KICK_PWM       = 8'd255;
  localparam logic [7:0]  RST_FLOOR_PWM      = 8'd60;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;
  localparam logic [1:0] DIR_BAD  = 2'd3;

  localparam int OUT_LW_BIT = 0;
  localparam int OUT_RW_BIT = 11;

  typedef struct packed {
    logic [1:0] dir;
    logic [7:0] pwm;
  } pins_t;

  typedef struct packed {
    logic [7:0]  slew_step;
    logic [15:0] kick_duration;
    logic [7:0]  kick_pwm;
    logic [7:0]  floor_pwm;
    logic        invert;
  } motor_cfg_t;

  typedef struct packed {
    logic  written;
    pins_t pins;
  } motor_res_t;

  function automatic pins_t drive_code(input logic signed [9:0] spd, input logic inv);
    logic signed [10:0] s;
    logic [MAG_W-1:0]   mag;
    pins_t              p;
    s = {spd[9], spd};
    if (inv) s = -s;
    p.dir = DIR_STOP;
    mag   = '0;
    if (s > 11'sd0) begin
      p.dir = DIR_FWD;
      mag   = MAG_W'(s);
    end else if (s < 11'sd0) begin
      p.dir = DIR_REV;
      mag   = MAG_W'(-s);
    end
    if (mag > MAG_W'(PWM_MAX)) mag = MAG_W'(PWM_MAX);
    p.pwm = mag[7:0];
    return p;
  endfunction

endpackage

>>> rtl/dmrk_motor.sv
// ---------------------------------------------------------------------------
// dmrk_motor
// Per-motor speed state: kickstart burst, ramp step and drive pin update.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmrk_motor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic                                  ramped,
  input  logic signed [dmrk_pkg::TGT_W-1:0]     target,
  input  dmrk_pkg::motor_cfg_t                  cfg,
  output dmrk_pkg::motor_res_t                  res
);

  logic signed [dmrk_pkg::SPEED_W-1:0]        speed_r, speed_nxt;
  logic                                       kick_on_r, kick_on_nxt;
  logic [dmrk_pkg::KICK_TIMER_WIDTH-1:0]      kick_age_r, kick_age_nxt;
  dmrk_pkg::pins_t                            pins_r;

  logic                                       trig;
  logic                                       kon1;
  logic [dmrk_pkg::KICK_TIMER_WIDTH-1:0]      age1;
  logic signed [dmrk_pkg::SPEED_W-1:0]        spd1;
  logic signed [10:0]                         spd_w, tgt_w, step_w, up, dn;
  logic [31:0]                                age_x, dur_x;
  logic signed [9:0]                          kick_s, m10, tgt10, abs_t, snap;

  always_comb begin
    trig = (speed_r == '0) && (target != '0) && !kick_on_r;
    kon1 = kick_on_r | trig;
    age1 = trig ? '0 : kick_age_r;

    spd_w  = 11'(speed_r);
    tgt_w  = 11'(target);
    step_w = $signed({3'b000, cfg.slew_step});
    up     = spd_w + step_w;
    dn     = spd_w - step_w;
    spd1   = speed_r;
    if (ramped && !kon1) begin
      if (spd_w < tgt_w) begin
        spd1 = (up > tgt_w) ? target : up[dmrk_pkg::SPEED_W-1:0];
      end else if (spd_w > tgt_w) begin
        spd1 = (dn < tgt_w) ? target : dn[dmrk_pkg::SPEED_W-1:0];
      end
    end

    age_x  = 32'(age1);
    dur_x  = 32'(cfg.kick_duration);
    kick_s = (target > 9'sd0) ? $signed({2'b00, cfg.kick_pwm})
                              : -$signed({2'b00, cfg.kick_pwm});
    m10    = $signed({2'b00, cfg.floor_pwm});
    tgt10  = 10'(target);
    abs_t  = (tgt10 < 10'sd0) ? -tgt10 : tgt10;
    snap   = (target > 9'sd0) ? m10 : -m10;
    if (abs_t < m10) snap = tgt10;

    speed_nxt    = spd1;
    kick_on_nxt  = kon1;
    kick_age_nxt = age1;
    res.written  = 1'b0;
    res.pins     = pins_r;
    if (kon1) begin
      res.written = 1'b1;
      if (age_x < dur_x) begin
        res.pins = dmrk_pkg::drive_code(kick_s, cfg.invert);
        if (age1 != dmrk_pkg::KICK_AGE_MAX) kick_age_nxt = age1 + 1'b1;
      end else begin
        kick_on_nxt = 1'b0;
        speed_nxt   = snap[dmrk_pkg::SPEED_W-1:0];
        res.pins    = dmrk_pkg::drive_code(snap, cfg.invert);
      end
    end else if (ramped) begin
      res.written = 1'b1;
      res.pins    = dmrk_pkg::drive_code(10'(spd1), cfg.invert);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= '0;
      kick_on_r  <= 1'b0;
      kick_age_r <= '0;
      pins_r     <= '0;
    end else if (step) begin
      speed_r    <= speed_nxt;
      kick_on_r  <= kick_on_nxt;
      kick_age_r <= kick_age_nxt;
      pins_r     <= res.pins;
    end
  end

  `ASSERT_CLK(a_dir_code, clk, rst_n, pins_r.dir != dmrk_pkg::DIR_BAD,
              "reserved dir code held")
  `ASSERT_CLK(a_kick_from_rest, clk, rst_n, $rose(kick_on_r) |-> ($past(speed_r) == '0),
              "burst started while moving")
  `ASSERT_CLK(a_idle_hold, clk, rst_n, (!step) |=> ($stable(speed_r) && $stable(pins_r)),
              "state moved without a transfer")

endmodule

>>> rtl/dual_motor_ramp_kickstart_core.sv
// ---------------------------------------------------------------------------
// dual_motor_ramp_kickstart_core
// Slew-rate limited dual motor drive with kickstart bursts from standstill.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per millisecond tick, carrying both signed targets.
//   out_* : one transfer per tick with the written flag, direction code and
//           PWM magnitude of each motor.
//   cfg_* : register writes (index, data), always ready; write only while
//           no tick is in flight.
// Path: an accepted tick passes the input register, one pass of per-motor
//   logic and the output register before it is presented on out_*.
// Throughput: one tick per clock while out_tready is high.
// Stall: while out_tready is low the result holds; one more tick is held in
//   the input register, then in_tready drops.
// Reset (rst_n low, synchronous): speeds, bursts, ramp counter and held pins
//   clear; registers return to defaults (period 5, step 2, burst 50,
//   burst PWM 255, floor PWM 60, no inversion).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_motor_ramp_kickstart_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // [8:0] target_left, [17:9] target_right, [23:18] zero
  input  logic [dmrk_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [0] left_written, [2:1] left_dir, [10:3] left_pwm, [11] right_written,
  // [13:12] right_dir, [21:14] right_pwm, [23:22] zero
  output logic [dmrk_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dmrk_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmrk_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [7:0]  ramp_period_r, slew_step_r, kick_pwm_r, floor_pwm_r;
  logic [15:0] kick_duration_r;
  logic        invert_left_r, invert_right_r;

  logic                                   s1_valid_r;
  logic signed [dmrk_pkg::TGT_W-1:0]      tgt_left_r, tgt_right_r;
  logic                                   out_valid_r;
  logic [dmrk_pkg::OUT_DATA_W-1:0]        out_data_r, out_data_nxt;
  logic [7:0]                             ramp_age_r, ramp_age_nxt;

  logic                                   step, ramped;
  logic [7:0]                             nage;
  dmrk_pkg::motor_cfg_t                   cfg_left, cfg_right;
  dmrk_pkg::motor_res_t                   res_left, res_right;

  assign cfg_ready  = 1'b1;
  assign step       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || step;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_period_r    <= dmrk_pkg::RST_RAMP_PERIOD;
      slew_step_r      <= dmrk_pkg::RST_SLEW_STEP;
      kick_duration_r  <= dmrk_pkg::RST_KICK_DURATION;
      kick_pwm_r       <= dmrk_pkg::RST_KICK_PWM;
      floor_pwm_r      <= dmrk_pkg::RST_FLOOR_PWM;
      invert_left_r    <= 1'b0;
      invert_right_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dmrk_pkg::REG_RAMP_PERIOD:    ramp_period_r    <= cfg_data[7:0];
        dmrk_pkg::REG_SLEW_STEP:      slew_step_r      <= cfg_data[7:0];
        dmrk_pkg::REG_KICK_DURATION:  kick_duration_r  <= cfg_data;
        dmrk_pkg::REG_KICK_PWM:       kick_pwm_r       <= cfg_data[7:0];
        dmrk_pkg::REG_FLOOR_PWM:      floor_pwm_r      <= cfg_data[7:0];
        dmrk_pkg::REG_INVERT_LEFT:    invert_left_r    <= cfg_data[0];
        dmrk_pkg::REG_INVERT_RIGHT:   invert_right_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nage         = (ramp_age_r == 8'hFF) ? 8'hFF : ramp_age_r + 8'd1;
    ramped       = (nage >= ramp_period_r);
    ramp_age_nxt = ramped ? 8'd0 : nage;

    cfg_left  = '{slew_step: slew_step_r, kick_duration: kick_duration_r,
                  kick_pwm: kick_pwm_r, floor_pwm: floor_pwm_r,
                  invert: invert_left_r};
    cfg_right = '{slew_step: slew_step_r, kick_duration: kick_duration_r,
                  kick_pwm: kick_pwm_r, floor_pwm: floor_pwm_r,
                  invert: invert_right_r};

    out_data_nxt = {2'b00, res_right.pins.pwm, res_right.pins.dir, res_right.written,
                    res_left.pins.pwm, res_left.pins.dir, res_left.written};
  end

  dmrk_motor u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ramped (ramped),
    .target (tgt_left_r),
    .cfg    (cfg_left),
    .res    (res_left)
  );

  dmrk_motor u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ramped (ramped),
    .target (tgt_right_r),
    .cfg    (cfg_right),
    .res    (res_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ramp_age_r  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        ramp_age_r  <= ramp_age_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tgt_left_r  <= $signed(in_tdata[8:0]);
      tgt_right_r <= $signed(in_tdata[17:9]);
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_CLK(a_step_out, clk, rst_n, step |=> out_valid_r,
              "transfer lost on the way to the output")
  `ASSERT_CLK(a_ramp_writes, clk, rst_n, (step && ramped) |=>
              (out_data_r[dmrk_pkg::OUT_LW_BIT] && out_data_r[dmrk_pkg::OUT_RW_BIT]),
              "ramp tick without pin update")
  `ASSERT_CLK(a_ready_empty, clk, rst_n, (!s1_valid_r) |-> in_tready,
              "input stalled while empty")

endmodule

>>> bench/dmrk_drive_checker.sv
// ----------------------------------------------------------------------------
// dmrk_drive_checker
// Watches the tick, result and register channels of the dual motor core,
// keeps its own model of speeds, bursts and held pins, and compares every
// result transfer field by field with the oldest predicted drive.
// ----------------------------------------------------------------------------
module dmrk_drive_checker
  import dmrk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       written;
    logic [1:0] dir;
    logic [7:0] pwm;
  } drive_t;

  // [1] right, [0] left
  typedef drive_t [1:0] tick_drive_t;

  logic [7:0]        ramp_period;
  logic [7:0]        slew_step;
  logic [15:0]       kick_duration;
  logic [7:0]        kick_pwm;
  logic [7:0]        min_moving;
  logic              invert [2];

  logic signed [8:0] speed [2];
  logic              kick_on [2];
  logic [15:0]       kick_age [2];
  logic [7:0]        ramp_age;
  drive_t            held [2];

  tick_drive_t       drive_due [$];
  int                bad_ticks = 0;

  function automatic drive_t pins_for(input int spd, input logic inv);
    int     s;
    int     mag;
    drive_t d;
    s = inv ? -spd : spd;
    d = '0;
    mag = 0;
    if (s > 0) begin
      d.dir = DIR_FWD;
      mag = s;
    end else if (s < 0) begin
      d.dir = DIR_REV;
      mag = -s;
    end else begin
      d.dir = DIR_STOP;
    end
    if (mag > PWM_MAX) mag = PWM_MAX;
    d.pwm = 8'(mag);
    return d;
  endfunction

  task automatic advance_motors(input logic [8:0] tl, input logic [8:0] tr,
                                output tick_drive_t res);
    int   tgt [2];
    int   nage;
    int   sp;
    int   k;
    int   m;
    int   a;
    logic ramped;
    tgt[0] = $signed(tl);
    tgt[1] = $signed(tr);
    for (int i = 0; i < 2; i++) begin
      if (speed[i] == 0 && tgt[i] != 0 && !kick_on[i]) begin
        kick_on[i] = 1'b1;
        kick_age[i] = '0;
      end
    end
    nage = (ramp_age < 8'd255) ? int'(ramp_age) + 1 : 255;
    ramped = (nage >= int'(ramp_period));
    ramp_age = ramped ? 8'd0 : 8'(nage);
    for (int i = 0; i < 2; i++) begin
      res[i] = held[i];
      res[i].written = 1'b0;
      if (ramped && !kick_on[i]) begin
        sp = speed[i];
        if (sp < tgt[i]) begin
          sp = sp + int'(slew_step);
          if (sp > tgt[i]) sp = tgt[i];
        end else if (sp > tgt[i]) begin
          sp = sp - int'(slew_step);
          if (sp < tgt[i]) sp = tgt[i];
        end
        speed[i] = 9'(sp);
      end
      if (kick_on[i]) begin
        if (kick_age[i] < kick_duration) begin
          k = kick_pwm;
          res[i] = pins_for(tgt[i] > 0 ? k : -k, invert[i]);
          if (kick_age[i] != '1) kick_age[i] = kick_age[i] + 16'd1;
        end else begin
          m = min_moving;
          a = (tgt[i] < 0) ? -tgt[i] : tgt[i];
          kick_on[i] = 1'b0;
          sp = (tgt[i] > 0) ? m : -m;
          if (a < m) sp = tgt[i];
          speed[i] = 9'(sp);
          res[i] = pins_for(sp, invert[i]);
        end
        res[i].written = 1'b1;
      end else if (ramped) begin
        res[i] = pins_for(speed[i], invert[i]);
        res[i].written = 1'b1;
      end
      held[i] = res[i];
    end
  endtask

  always @(posedge clk) begin
    tick_drive_t want;
    tick_drive_t got;
    if (!rst_n) begin
      ramp_period   = RST_RAMP_PERIOD;
      slew_step     = RST_SLEW_STEP;
      kick_duration = RST_KICK_DURATION;
      kick_pwm      = RST_KICK_PWM;
      min_moving    = RST_FLOOR_PWM;
      ramp_age      = '0;
      for (int i = 0; i < 2; i++) begin
        invert[i]   = 1'b0;
        speed[i]    = '0;
        kick_on[i]  = 1'b0;
        kick_age[i] = '0;
        held[i]     = '0;
      end
      drive_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAMP_PERIOD:    ramp_period   = cfg_data[7:0];
          REG_SLEW_STEP:      slew_step     = cfg_data[7:0];
          REG_KICK_DURATION:  kick_duration = cfg_data[15:0];
          REG_KICK_PWM:       kick_pwm      = cfg_data[7:0];
          REG_FLOOR_PWM:      min_moving    = cfg_data[7:0];
          REG_INVERT_LEFT:    invert[0]     = cfg_data[0];
          REG_INVERT_RIGHT:   invert[1]     = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got[0] = '{written: out_tdata[0], dir: out_tdata[2:1], pwm: out_tdata[10:3]};
        got[1] = '{written: out_tdata[11], dir: out_tdata[13:12],
                   pwm: out_tdata[21:14]};
        if (drive_due.size() == 0) begin
          bad_ticks++;
          if (bad_ticks <= 10)
            $display("%0t: result transfer with no tick pending, data %h", $realtime,
                     out_tdata);
        end else begin
          want = drive_due.pop_front();
          if (got[0].written !== want[0].written || got[0].dir !== want[0].dir ||
              got[0].pwm !== want[0].pwm || got[1].written !== want[1].written ||
              got[1].dir !== want[1].dir || got[1].pwm !== want[1].pwm) begin
            bad_ticks++;
            if (bad_ticks <= 10) begin
              $write("%0t: drive mismatch exp L(w%0d d%0d p%0d) R(w%0d d%0d p%0d)",
                     $realtime, want[0].written, want[0].dir, want[0].pwm,
                     want[1].written, want[1].dir, want[1].pwm);
              $display(" got L(w%0d d%0d p%0d) R(w%0d d%0d p%0d)",
                       got[0].written, got[0].dir, got[0].pwm,
                       got[1].written, got[1].dir, got[1].pwm);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_motors(in_tdata[8:0], in_tdata[17:9], want);
        drive_due.push_back(want);
      end
    end
    pending    <= drive_due.size();
    fail_count <= bad_ticks;
  end

endmodule

>>> bench/tb_dual_motor_ramp_kickstart_core.sv
// ----------------------------------------------------------------------------
// tb_dual_motor_ramp_kickstart_core
// Drives millisecond ticks of left/right targets into the core through a
// short directed sequence and then random phases under varied register
// settings, with random gaps and stalls on both streams; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dual_motor_ramp_kickstart_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dmrk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int LONG_HOLD   = 64;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 165;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  int                    tx_gap_pct = 0;
  int                    rx_stall_pct = 0;
  bit                    hold_off_req = 1'b0;
  logic [8:0]            run_tgt [2] = '{9'd0, 9'd0};
  int                    run_left [2] = '{0, 0};

  always #5 clk = ~clk;

  dual_motor_ramp_kickstart_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dmrk_drive_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    #5_000_000;
    $display("FAIL dual_motor_ramp_kickstart_core");
    $finish;
  end

  function automatic int gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [8:0] tl, input logic [8:0] tr);
    in_tdata  <= {{(IN_DATA_W-18){1'b0}}, tr, tl};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_repeat(input logic [8:0] tl, input logic [8:0] tr, input int n);
    repeat (n) send_tick(tl, tr);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [7:0] ri, input logic [7:0] rs,
                                input logic [15:0] kd, input logic [7:0] kp,
                                input logic [7:0] mm, input logic il, input logic ir);
    cfg_write(REG_RAMP_PERIOD, {8'd0, ri});
    cfg_write(REG_SLEW_STEP, {8'd0, rs});
    cfg_write(REG_KICK_DURATION, kd);
    cfg_write(REG_KICK_PWM, {8'd0, kp});
    cfg_write(REG_FLOOR_PWM, {8'd0, mm});
    cfg_write(REG_INVERT_LEFT, {15'd0, il});
    cfg_write(REG_INVERT_RIGHT, {15'd0, ir});
    cfg_write(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // targets mostly held for a run of ticks, with some per-tick noise
  task automatic next_targets(output logic [8:0] tl, output logic [8:0] tr);
    logic [8:0] t [2];
    for (int i = 0; i < 2; i++) begin
      if ($urandom_range(6) == 0) begin
        t[i] = 9'($urandom_range(511));
      end else begin
        if (run_left[i] == 0) begin
          case ($urandom_range(9))
            0, 1: run_tgt[i] = 9'd0;
            2: begin
              case ($urandom_range(4))
                0: run_tgt[i] = 9'h100;
                1: run_tgt[i] = 9'h0FF;
                2: run_tgt[i] = 9'h101;
                3: run_tgt[i] = 9'h001;
                default: run_tgt[i] = 9'h1FF;
              endcase
            end
            default: run_tgt[i] = 9'(int'($urandom_range(510)) - 255);
          endcase
          run_left[i] = ($urandom_range(4) == 0) ? $urandom_range(200, 40)
                                                 : $urandom_range(40, 1);
        end
        run_left[i]--;
        t[i] = run_tgt[i];
      end
    end
    tl = t[0];
    tr = t[1];
  endtask

  initial begin
    logic [8:0] tl;
    logic [8:0] tr;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // burst end snap, ramp saturation, inverted zero, zero target in a burst
    apply_settings(8'd1, 8'd255, 16'd2, 8'd255, 8'd60, 1'b0, 1'b1);
    send_repeat(9'h0FF, 9'h100, 4);
    send_repeat(9'h000, 9'h000, 2);
    send_repeat(9'h1FF, 9'h001, 1);
    send_repeat(9'h000, 9'h000, 3);
    drain();

    // zero burst length, ramp every tick, zero PWM values
    apply_settings(8'd0, 8'd1, 16'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    send_repeat(9'h100, 9'h0FF, 2);
    send_repeat(9'h005, 9'h1FB, 2);
    send_repeat(9'h000, 9'h000, 1);
    drain();

    // longest burst, slowest ramp, target below the floor PWM
    apply_settings(8'd255, 8'd1, 16'hFFFF, 8'd128, 8'd255, 1'b1, 1'b1);
    send_repeat(9'h064, 9'h19C, 4);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(RST_RAMP_PERIOD, RST_SLEW_STEP, RST_KICK_DURATION,
                          RST_KICK_PWM, RST_FLOOR_PWM, 1'b0, 1'b0);
        1: apply_settings(8'd1, 8'd1, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        2: apply_settings(8'd255, 8'd255, 16'd1, 8'd255, 8'd255, 1'b1, 1'b1);
        default: apply_settings(
                   ($urandom_range(9) == 0) ? 8'($urandom_range(1) * 255)
                                            : 8'($urandom_range(12, 1)),
                   $urandom_range(1) ? 8'($urandom_range(8, 1))
                                     : 8'($urandom_range(255, 1)),
                   ($urandom_range(9) == 0) ? 16'($urandom_range(400))
                                            : 16'($urandom_range(30)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      endcase
      tx_gap_pct   = (p % 3 == 0) ? 0 : $urandom_range(50, 10);
      rx_stall_pct = (p % 4 == 0) ? 0 : $urandom_range(50, 10);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (p == 3 && n == 60) hold_off_req = 1'b1;
        if (p == 3 && n == 120) drain();
        next_targets(tl, tr);
        send_tick(tl, tr);
      end
      drain();
    end

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS dual_motor_ramp_kickstart_core");
    end else begin
      $display("FAIL dual_motor_ramp_kickstart_core");
    end
    $finish;
  end

endmodule
